>>> src/ncf_pkg.sv
// Package for the nested comment flattener: character codes, result kinds,
// error codes, hold codes and the result record type.
// No dependencies.
package ncf_pkg;

    typedef logic [7:0]  t_char;
    typedef logic [1:0]  t_kind;
    typedef logic [2:0]  t_err;
    typedef logic [1:0]  t_hold;
    typedef logic [15:0] t_pos;

    localparam t_char CH_LBRACE  = 8'h7B;
    localparam t_char CH_RBRACE  = 8'h7D;
    localparam t_char CH_LPAREN  = 8'h28;
    localparam t_char CH_STAR    = 8'h2A;
    localparam t_char CH_RPAREN  = 8'h29;
    localparam t_char CH_DQUOTE  = 8'h22;
    localparam t_char CH_NEWLINE = 8'h0A;

    localparam t_kind OUT_CHAR  = 2'd0;
    localparam t_kind OUT_ERROR = 2'd1;
    localparam t_kind OUT_END   = 2'd2;

    localparam t_err ERR_STRAY_BRACE    = 3'd0;
    localparam t_err ERR_BRACE_MISMATCH = 3'd1;
    localparam t_err ERR_STRAY_PAREN    = 3'd2;
    localparam t_err ERR_PAREN_MISMATCH = 3'd3;
    localparam t_err ERR_UNCLOSED       = 3'd4;
    localparam t_err ERR_OVERFLOW       = 3'd5;

    localparam t_hold HOLD_NONE  = 2'd0;
    localparam t_hold HOLD_PAREN = 2'd1;
    localparam t_hold HOLD_STAR  = 2'd2;

    localparam logic KIND_BRACE = 1'b0;
    localparam logic KIND_PAREN = 1'b1;

    localparam logic REG_QUOTE = 1'b0;

    typedef struct packed {
        t_kind kind;
        t_char ch;
        t_err  code;
        t_pos  line;
        t_pos  col;
        logic  last;
    } t_result;

endpackage

>>> src/nested_comment_flattener.sv
// Top level of the nested comment flattener: state update, opener stack and
// result buffer for Pascal-style comment nesting checks.
// Depends on ncf_pkg.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------------
//  input    | i_valid / o_stall     | i_text_char, i_end_of_text
//  output   | o_valid / i_stall     | o_out_kind, o_out_char, o_error_code,
//           |                       | o_error_line, o_error_column, o_last
//  config   | psel/penable/pwrite   | paddr, pwdata, prdata, pready
//
// One character per cycle is taken while o_stall is low, and updates state then.
// A request that gives k results (k is 0 to 3) sends them one by one through the
// single result port; the next request enters in the cycle the last one leaves.
// Entries sit in a memory; the top and the one below it are also in registers.
// Reset (synchronous) clears count, column and flags; the stack needs no clearing.
// A stall on the output holds the result; the input then stalls in turn.
module nested_comment_flattener #(
    parameter int STACK_DEPTH   = 32,
    parameter int POSITION_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  ncf_pkg::t_char i_text_char,
    input  logic           i_end_of_text,
    output logic           o_valid,
    input  logic           i_stall,
    output ncf_pkg::t_kind o_out_kind,
    output ncf_pkg::t_char o_out_char,
    output ncf_pkg::t_err  o_error_code,
    output ncf_pkg::t_pos  o_error_line,
    output ncf_pkg::t_pos  o_error_column,
    output logic           o_last,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import ncf_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int PB    = POSITION_BITS;
    localparam int ENT_W = 1 + 2 * PB;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);
    localparam logic [PB-1:0]    POS_MAX = '1;

    logic [CNT_W-1:0] r_count, n_count;
    logic [PB-1:0]    r_line, n_line;
    logic [PB-1:0]    r_col, n_col;
    logic             r_in_str, n_in_str;
    t_hold            r_held, n_held;
    logic             r_err, n_err;
    t_char            r_quote;
    logic [ENT_W-1:0] r_top;
    logic [ENT_W-1:0] r_below;
    logic [ENT_W-1:0] r_mem [STACK_DEPTH];
    t_result          r_buf [3];
    logic [1:0]       r_nbuf;

    logic             w_accept, w_take, w_cfg_wr;
    logic             do_push, do_pop, do_open, do_close, op_kind;
    logic [PB-1:0]    w_col_inc, w_line_inc;
    logic             w_top_kind;
    logic [PB+15:0]   w_rep_line_x, w_rep_col_x, w_top_line_x, w_top_col_x;
    logic             va, vb, vc;
    t_result          res_a, res_b, res_c;
    t_result          n_res [3];
    logic [1:0]       nr;
    logic [CNT_W-1:0] w_cnt_next;
    logic [CNT_W-1:0] w_rd_cnt;
    logic [IDX_W-1:0] w_rd_addr;

    assign w_take   = o_valid && !i_stall;
    assign o_stall  = !((r_nbuf == 2'd0) || ((r_nbuf == 2'd1) && w_take));
    assign w_accept = i_valid && !o_stall;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_QUOTE) ? {24'd0, r_quote} : 32'd0;

    assign w_col_inc  = (r_col == POS_MAX) ? r_col : r_col + PB'(1);
    assign w_line_inc = (r_line == POS_MAX) ? r_line : r_line + PB'(1);
    assign w_top_kind = r_top[ENT_W-1];
    assign w_rep_line_x = {16'd0, r_line};
    assign w_rep_col_x  = {16'd0, w_col_inc};
    assign w_top_line_x = {16'd0, r_top[2*PB-1:PB]};
    assign w_top_col_x  = {16'd0, r_top[PB-1:0]};

    always_comb begin
        n_count  = r_count;
        n_line   = r_line;
        n_col    = r_col;
        n_in_str = r_in_str;
        n_held   = r_held;
        n_err    = r_err;
        do_push  = 1'b0;
        do_pop   = 1'b0;
        do_open  = 1'b0;
        do_close = 1'b0;
        op_kind  = KIND_BRACE;
        va = 1'b0;
        vb = 1'b0;
        vc = 1'b0;
        res_a = '0;
        res_b = '0;
        res_c = '0;
        if (i_end_of_text) begin
            if (!r_err) begin
                if (r_held != HOLD_NONE) begin
                    va = 1'b1;
                    res_a.kind = OUT_CHAR;
                    res_a.ch = (r_held == HOLD_PAREN) ? CH_LPAREN : CH_STAR;
                end
                if (r_count != '0) begin
                    vb = 1'b1;
                    res_b.kind = OUT_ERROR;
                    res_b.code = ERR_UNCLOSED;
                    res_b.line = w_top_line_x[15:0];
                    res_b.col  = w_top_col_x[15:0];
                end
            end
            vc = 1'b1;
            res_c.kind = OUT_END;
            n_count  = '0;
            n_line   = PB'(1);
            n_col    = '0;
            n_in_str = 1'b0;
            n_held   = HOLD_NONE;
            n_err    = 1'b0;
        end else if (!r_err) begin
            n_held = HOLD_NONE;
            if (r_held == HOLD_PAREN && i_text_char == CH_STAR) begin
                n_col   = w_col_inc;
                do_open = 1'b1;
                op_kind = KIND_PAREN;
            end else if (r_held == HOLD_STAR && i_text_char == CH_RPAREN) begin
                n_col    = w_col_inc;
                do_close = 1'b1;
                op_kind  = KIND_PAREN;
            end else begin
                if (r_held != HOLD_NONE) begin
                    va = 1'b1;
                    res_a.kind = OUT_CHAR;
                    res_a.ch = (r_held == HOLD_PAREN) ? CH_LPAREN : CH_STAR;
                end
                res_b.kind = OUT_CHAR;
                res_b.ch   = i_text_char;
                if (i_text_char == CH_NEWLINE) begin
                    n_line = w_line_inc;
                    n_col  = '0;
                    vb     = 1'b1;
                end else begin
                    n_col = w_col_inc;
                    if (r_in_str) begin
                        if (i_text_char == r_quote) begin
                            n_in_str = 1'b0;
                        end
                        vb = 1'b1;
                    end else if (i_text_char == r_quote) begin
                        n_in_str = 1'b1;
                        vb = 1'b1;
                    end else if (i_text_char == CH_LPAREN) begin
                        n_held = HOLD_PAREN;
                    end else if (i_text_char == CH_STAR) begin
                        n_held = HOLD_STAR;
                    end else if (i_text_char == CH_LBRACE) begin
                        do_open = 1'b1;
                    end else if (i_text_char == CH_RBRACE) begin
                        do_close = 1'b1;
                    end else begin
                        vb = 1'b1;
                    end
                end
            end
            if (do_open) begin
                if (r_count >= DEPTH_C) begin
                    vb = 1'b1;
                    res_b.kind = OUT_ERROR;
                    res_b.ch   = '0;
                    res_b.code = ERR_OVERFLOW;
                    res_b.line = w_rep_line_x[15:0];
                    res_b.col  = w_rep_col_x[15:0];
                    n_err = 1'b1;
                end else begin
                    do_push = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    if (r_count == '0) begin
                        vb = 1'b1;
                        res_b.kind = OUT_CHAR;
                        res_b.ch   = CH_LBRACE;
                    end
                end
            end
            if (do_close) begin
                if (r_count == '0 || w_top_kind != op_kind) begin
                    vb = 1'b1;
                    res_b.kind = OUT_ERROR;
                    res_b.ch   = '0;
                    res_b.line = w_rep_line_x[15:0];
                    res_b.col  = w_rep_col_x[15:0];
                    n_err = 1'b1;
                    if (r_count == '0) begin
                        res_b.code = (op_kind == KIND_BRACE) ? ERR_STRAY_BRACE
                                                             : ERR_STRAY_PAREN;
                    end else begin
                        res_b.code = (op_kind == KIND_BRACE) ? ERR_BRACE_MISMATCH
                                                             : ERR_PAREN_MISMATCH;
                    end
                end else begin
                    do_pop  = 1'b1;
                    n_count = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        vb = 1'b1;
                        res_b.kind = OUT_CHAR;
                        res_b.ch   = CH_RBRACE;
                    end
                end
            end
        end
    end

    // pack the candidate results in order and mark the final one
    always_comb begin
        n_res[0] = '0;
        n_res[1] = '0;
        n_res[2] = '0;
        nr = 2'd0;
        if (va) begin
            n_res[nr] = res_a;
            nr = nr + 2'd1;
        end
        if (vb) begin
            n_res[nr] = res_b;
            nr = nr + 2'd1;
        end
        if (vc) begin
            n_res[nr] = res_c;
            nr = nr + 2'd1;
        end
        for (int i = 0; i < 3; i++) begin
            n_res[i].last = (2'(i) == nr - 2'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_line   <= PB'(1);
            r_col    <= '0;
            r_in_str <= 1'b0;
            r_held   <= HOLD_NONE;
            r_err    <= 1'b0;
            r_quote  <= CH_DQUOTE;
            r_nbuf   <= 2'd0;
        end else begin
            if (w_cfg_wr && paddr[2] == REG_QUOTE) begin
                r_quote <= pwdata[7:0];
            end
            if (w_accept) begin
                r_count  <= n_count;
                r_line   <= n_line;
                r_col    <= n_col;
                r_in_str <= n_in_str;
                r_held   <= n_held;
                r_err    <= n_err;
                r_nbuf   <= nr;
            end else if (w_take) begin
                r_nbuf <= r_nbuf - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_buf[0] <= n_res[0];
            r_buf[1] <= n_res[1];
            r_buf[2] <= n_res[2];
        end else if (w_take) begin
            r_buf[0] <= r_buf[1];
            r_buf[1] <= r_buf[2];
        end
        if (w_accept && do_push) begin
            r_top <= {op_kind, r_line, w_col_inc};
        end else if (w_accept && do_pop) begin
            r_top <= r_below;
        end
    end

    // stack memory: r_below tracks the entry under the top
    assign w_cnt_next = w_accept ? n_count : r_count;
    assign w_rd_cnt   = w_cnt_next - CNT_W'(2);
    assign w_rd_addr  = w_rd_cnt[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_accept && do_push) begin
            r_mem[r_count[IDX_W-1:0]] <= {op_kind, r_line, w_col_inc};
        end
        r_below <= r_mem[w_rd_addr];
    end

    assign o_valid        = (r_nbuf != 2'd0);
    assign o_out_kind     = r_buf[0].kind;
    assign o_out_char     = r_buf[0].ch;
    assign o_error_code   = r_buf[0].code;
    assign o_error_line   = r_buf[0].line;
    assign o_error_column = r_buf[0].col;
    assign o_last         = r_buf[0].last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("stack count beyond depth");

    a_quiet_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !i_end_of_text && r_err |=> r_nbuf == 2'd0)
        else $error("result after error");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_end_of_text |=> r_count == '0 && !r_err && r_held == HOLD_NONE
            && !r_in_str && r_nbuf != 2'd0)
        else $error("end of text did not clear state");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_kind == OUT_END |-> o_last)
        else $error("end marker not last");

endmodule
